// ===== sv/pspr_pkg.sv =====
// Shared types and constants for the PLL synthesizer register programmer.
// No dependencies; imported by every module of the block.
package pspr_pkg;

	localparam int FREQ_W  = 23;
	localparam int PWR_W   = 2;
	localparam int DIV_W   = 3;
	localparam int N_W     = 10;
	localparam int F_W     = 12;
	localparam int WORD_W  = 32;
	localparam int IDX_W   = 3;
	localparam int CFG_IDX_W = 3;

	// Divider range limits in kHz
	localparam logic [FREQ_W-1:0] THR_D0  = 23'd3000000;
	localparam logic [FREQ_W-1:0] THR_D1  = 23'd1500000;
	localparam logic [FREQ_W-1:0] THR_D2  = 23'd750000;
	localparam logic [FREQ_W-1:0] THR_D3  = 23'd375000;
	localparam logic [FREQ_W-1:0] THR_D4  = 23'd187500;
	localparam logic [FREQ_W-1:0] THR_D5  = 23'd93750;
	localparam logic [FREQ_W-1:0] THR_D6  = 23'd46880;
	localparam logic [FREQ_W-1:0] THR_LOW = 23'd23500;

	// x / 10000 == (x * RECIP_10K) >> 37 for x < 2^23
	localparam logic [23:0] RECIP_10K = 24'd13743896;
	localparam int          SHIFT_10K = 37;
	localparam logic [13:0] TEN_K     = 14'd10000;
	// y / 5 == (y * RECIP_5) >> 18 for y < 2^15
	localparam logic [15:0] RECIP_5   = 16'd52429;
	localparam int          SHIFT_5   = 18;

	localparam logic [WORD_W-1:0] REG4_BASE = 32'h608C_8124;

	localparam logic [IDX_W-1:0] FIRST_IDX = 3'd5;
	localparam logic [IDX_W-1:0] IDX_R0 = 3'd0;
	localparam logic [IDX_W-1:0] IDX_R1 = 3'd1;
	localparam logic [IDX_W-1:0] IDX_R2 = 3'd2;
	localparam logic [IDX_W-1:0] IDX_R3 = 3'd3;
	localparam logic [IDX_W-1:0] IDX_R4 = 3'd4;
	localparam logic [IDX_W-1:0] IDX_R5 = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_WORD_REG1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_REG2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_REG3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_REG5 = 3'd3;

	localparam logic [WORD_W-1:0] RST_WORD_REG1 = 32'h2001_7D01;
	localparam logic [WORD_W-1:0] RST_WORD_REG2 = 32'h1000_4D42;
	localparam logic [WORD_W-1:0] RST_WORD_REG3 = 32'h0000_1F23;
	localparam logic [WORD_W-1:0] RST_WORD_REG5 = 32'h0045_8005;

	typedef struct packed {
		logic              kind;
		logic              err;
		logic [DIV_W-1:0]  div;
		logic [PWR_W-1:0]  pwr;
		logic [N_W-1:0]    n;
		logic [F_W-1:0]    f;
	} job_t;

	typedef struct packed {
		logic [WORD_W-1:0] reg1;
		logic [WORD_W-1:0] reg2;
		logic [WORD_W-1:0] reg3;
		logic [WORD_W-1:0] reg5;
	} cfg_words_t;

	function automatic logic [WORD_W-1:0] init_word(input logic [IDX_W-1:0] idx);
		logic [WORD_W-1:0] w;
		unique case (idx)
			IDX_R0:  w = 32'h0079_0000;
			IDX_R1:  w = 32'h2000_CE21;
			IDX_R2:  w = 32'h1100_9EC2;
			IDX_R3:  w = 32'h0000_0283;
			IDX_R4:  w = 32'h63E2_01FC;
			IDX_R5:  w = 32'h0144_0005;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// ===== sv/pspr_front.sv =====
// Front end: accepts requests, picks the output divider, computes N and F.
// Four-stage pipeline feeding the job queue; uses pspr_pkg.
module pspr_front
	import pspr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_kind,
	input  logic [FREQ_W-1:0] in_freq,
	input  logic [PWR_W-1:0]  in_pwr,
	output logic              push,
	input  logic              full,
	output job_t              push_job
);

	logic              adv;
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [DIV_W-1:0]  div_c;
	logic              err_c;
	logic [FREQ_W-1:0] scaled_c;

	logic              kind_s1, kind_s2, kind_s3, kind_s4;
	logic              err_s1, err_s2, err_s3, err_s4;
	logic [DIV_W-1:0]  div_s1, div_s2, div_s3, div_s4;
	logic [PWR_W-1:0]  pwr_s1, pwr_s2, pwr_s3, pwr_s4;
	logic [FREQ_W-1:0] scaled_s1, scaled_s2, scaled_s3;
	logic [46:0]       prod_s2;
	logic [N_W-1:0]    n_s3, n_s4;
	logic [23:0]       qm_s3;
	logic [FREQ_W-1:0] diff_c;
	logic [14:0]       rem2_c;
	logic [29:0]       fprod_s4;

	assign adv      = !v_s4 || !full;
	assign in_ready = adv;
	assign push     = v_s4 && !full;

	always_comb begin
		err_c = 1'b0;
		if (in_freq > THR_D0) begin
			div_c = 3'd0;
		end else if (in_freq > THR_D1) begin
			div_c = 3'd1;
		end else if (in_freq > THR_D2) begin
			div_c = 3'd2;
		end else if (in_freq > THR_D3) begin
			div_c = 3'd3;
		end else if (in_freq > THR_D4) begin
			div_c = 3'd4;
		end else if (in_freq > THR_D5) begin
			div_c = 3'd5;
		end else if (in_freq > THR_D6) begin
			div_c = 3'd6;
		end else begin
			div_c = 3'd7;
			err_c = (in_freq <= THR_LOW);
		end
		// scaled value always fits 23 bits
		scaled_c = in_freq << div_c;
	end

	always_comb begin
		diff_c = scaled_s3 - FREQ_W'(qm_s3);
		rem2_c = {diff_c[13:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1   <= in_kind;
			err_s1    <= err_c;
			div_s1    <= div_c;
			pwr_s1    <= in_pwr;
			scaled_s1 <= scaled_c;

			kind_s2   <= kind_s1;
			err_s2    <= err_s1;
			div_s2    <= div_s1;
			pwr_s2    <= pwr_s1;
			scaled_s2 <= scaled_s1;
			prod_s2   <= 47'(scaled_s1) * 47'(RECIP_10K);

			kind_s3   <= kind_s2;
			err_s3    <= err_s2;
			div_s3    <= div_s2;
			pwr_s3    <= pwr_s2;
			scaled_s3 <= scaled_s2;
			n_s3      <= prod_s2[SHIFT_10K +: N_W];
			qm_s3     <= 24'(prod_s2[SHIFT_10K +: N_W]) * 24'(TEN_K);

			kind_s4   <= kind_s3;
			err_s4    <= err_s3;
			div_s4    <= div_s3;
			pwr_s4    <= pwr_s3;
			n_s4      <= n_s3;
			fprod_s4  <= 30'(rem2_c) * 30'(RECIP_5);
		end
	end

	always_comb begin
		push_job.kind = kind_s4;
		push_job.err  = kind_s4 && err_s4;
		push_job.div  = div_s4;
		push_job.pwr  = pwr_s4;
		push_job.n    = n_s4;
		push_job.f    = fprod_s4[SHIFT_5 +: F_W];
	end

endmodule

// ===== sv/pspr_queue.sv =====
// Short job queue between front end and word emitter.
// Register-based FIFO of job_t entries; uses pspr_pkg.
module pspr_queue
	import pspr_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== sv/pspr_back.sv =====
// Back end: walks each queued job from register 5 down to 0 (an error job
// yields one word at index 0) and drives the registered output channel; uses pspr_pkg.
module pspr_back
	import pspr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  job_t              head,
	output logic              pop,
	input  cfg_words_t        cfg,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] out_word,
	output logic [IDX_W-1:0]  out_idx,
	output logic              out_last,
	output logic              out_err
);

	logic [IDX_W-1:0]  cnt_q;
	logic              fire;
	logic [WORD_W-1:0] word_c;
	logic [IDX_W-1:0]  idx_c;
	logic              last_c;

	assign fire = !empty && (!out_valid || out_ready);
	assign pop  = fire && last_c;

	always_comb begin
		idx_c  = cnt_q;
		last_c = (cnt_q == IDX_R0);
		if (head.err) begin
			idx_c  = IDX_R0;
			last_c = 1'b1;
			word_c = '0;
		end else if (!head.kind) begin
			word_c = init_word(cnt_q);
		end else begin
			unique case (cnt_q)
				IDX_R0:  word_c = (WORD_W'(head.n) << 15) | (WORD_W'(head.f) << 3);
				IDX_R1:  word_c = cfg.reg1;
				IDX_R2:  word_c = cfg.reg2;
				IDX_R3:  word_c = cfg.reg3;
				IDX_R4:  word_c = REG4_BASE | (WORD_W'(head.div) << 20)
					| (WORD_W'(head.pwr) << 6) | (WORD_W'(head.pwr) << 3);
				IDX_R5:  word_c = cfg.reg5;
				default: word_c = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			cnt_q     <= FIRST_IDX;
		end else if (fire) begin
			out_valid <= 1'b1;
			cnt_q     <= last_c ? FIRST_IDX : cnt_q - 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_word <= word_c;
			out_idx  <= idx_c;
			out_last <= last_c;
			out_err  <= head.err;
		end
	end

endmodule

// ===== sv/pll_synth_register_programmer_core.sv =====
// PLL synthesizer register programmer, top level.
// Holds the configuration words; instantiates pspr_front, pspr_queue, pspr_back.
//
// Slave stream: one item per request. tuser selects init table (0) or
// frequency (1); tdata carries frequency in kHz and the output power code.
// Master stream: one item per register word, register 5 first, register 0
// last with tlast set. tuser flags a frequency of 23500 kHz or less; such a
// request yields one item with a zero word, index 0 and tlast set.
// Configuration: cfg_wr_en writes cfg_wr_data to the operating word chosen
// by cfg_wr_index (0..3 = registers 1, 2, 3, 5); other indexes are ignored.
// Path: the first word of a request is valid once it has passed the four
// front stages, the queue and the output register.
// Throughput: six words per request, one word per cycle on the master
// channel while the receiver is ready; a single word for a rejected
// frequency. The front pipeline and queue keep accepting requests while
// the emitter works or the receiver stalls. A stalled receiver holds the
// current item; the queue fills, then s_tready drops. Reset clears
// pipeline, queue and output valid, and loads the default operating words.
module pll_synth_register_programmer_core
	import pspr_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,       // frequency_khz[22:0], power_level[24:23]
	input  logic                 s_tuser,       // kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,       // reg_word[31:0], reg_index[34:32]
	output logic                 m_tuser,       // error
	output logic                 m_tlast,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_wr_index,
	input  logic [WORD_W-1:0]    cfg_wr_data
);

	cfg_words_t        cfg_q;
	logic              push, full, pop, empty;
	job_t              push_job, head;
	logic [WORD_W-1:0] out_word;
	logic [IDX_W-1:0]  out_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reg1 <= RST_WORD_REG1;
			cfg_q.reg2 <= RST_WORD_REG2;
			cfg_q.reg3 <= RST_WORD_REG3;
			cfg_q.reg5 <= RST_WORD_REG5;
		end else if (cfg_wr_en) begin
			unique case (cfg_wr_index)
				CFG_WORD_REG1: cfg_q.reg1 <= cfg_wr_data;
				CFG_WORD_REG2: cfg_q.reg2 <= cfg_wr_data;
				CFG_WORD_REG3: cfg_q.reg3 <= cfg_wr_data;
				CFG_WORD_REG5: cfg_q.reg5 <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	pspr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.in_freq  (s_tdata[FREQ_W-1:0]),
		.in_pwr   (s_tdata[FREQ_W +: PWR_W]),
		.push     (push),
		.full     (full),
		.push_job (push_job)
	);

	pspr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	pspr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word),
		.out_idx   (out_idx),
		.out_last  (m_tlast),
		.out_err   (m_tuser)
	);

	assign m_tdata = {5'b0, out_idx, out_word};

endmodule
